### sv/qrs_pkg.sv
// ============================================================================
// qrs_pkg
// shared types and constants of the quadratic root solver
// ============================================================================
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;   // default coefficient width, q8.8
    localparam int PREC_W         = 15;   // precision register width
    localparam int FRAC_W         = 16;   // fraction bits of a root
    localparam int ROOT_W         = 32;   // root width, q16.16
    localparam int SQRT_IN_W      = 64;   // radicand width
    localparam int SQRT_OUT_W     = 32;   // square root width
    localparam int KW             = 5;    // normalize shift count, 0..16
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;

    localparam logic [PREC_W-1:0] PREC_RESET = 15'd1;
    localparam logic [0:0]        REG_PRECISION = 1'b0;

    // result status, also used as the item class down the pipeline
    typedef enum logic [1:0] {
        ST_DEGEN   = 2'd0,
        ST_NO_REAL = 2'd1,
        ST_LINEAR  = 2'd2,
        ST_TWO     = 2'd3
    } status_t;

    // control that travels with every beat
    typedef struct packed {
        logic          vld;
        status_t       mode;
        logic [KW-1:0] k;       // radicand scaled by 4^k
        logic          huge;    // radicand taken as d/4, root doubled
        logic          neg_p;   // sign of the plus-branch quotient
        logic          neg_m;   // sign of the minus-branch quotient
    } ctl_t;

endpackage

### sv/qrs_front.sv
// ============================================================================
// qrs_front
// classify, multiply, form the discriminant and normalize the radicand
// ============================================================================
module qrs_front #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_vld,
    input  logic signed [COEF_WIDTH-1:0]         coef_a,
    input  logic signed [COEF_WIDTH-1:0]         coef_b,
    input  logic signed [COEF_WIDTH-1:0]         coef_c,
    input  logic [qrs_pkg::PREC_W-1:0]           precision,
    output qrs_pkg::ctl_t                        ctl,
    output logic [qrs_pkg::SQRT_IN_W-1:0]        x,
    output logic signed [COEF_WIDTH-1:0]         a,
    output logic signed [COEF_WIDTH-1:0]         b,
    output logic signed [COEF_WIDTH-1:0]         c
);

    localparam int W   = COEF_WIDTH;
    localparam int PW  = (W > qrs_pkg::PREC_W) ? W : qrs_pkg::PREC_W;
    localparam int DXW = (2*W+2 > 66) ? 2*W+2 : 66;
    localparam int XW  = qrs_pkg::SQRT_IN_W;
    localparam int KW  = qrs_pkg::KW;
    localparam int KMAX = qrs_pkg::FRAC_W;

    // stage 1: class and products
    logic [W-1:0]               abs_a;
    logic [W-1:0]               abs_b;
    logic [qrs_pkg::PREC_W-1:0] prec_eff;
    logic                       a_small;
    logic                       b_small;
    qrs_pkg::status_t           mode1_next;
    logic [2*W-1:0]             b2_next;
    logic signed [2*W-1:0]      ax;
    logic signed [2*W-1:0]      cx;
    logic signed [2*W-1:0]      ac_next;

    logic                       vld1_reg;
    qrs_pkg::status_t           mode1_reg;
    logic [2*W-1:0]             b2_reg;
    logic signed [2*W-1:0]      ac_reg;
    logic signed [W-1:0]        a1_reg;
    logic signed [W-1:0]        b1_reg;
    logic signed [W-1:0]        c1_reg;

    always_comb
    begin
        abs_a      = coef_a[W-1] ? -coef_a : coef_a;
        abs_b      = coef_b[W-1] ? -coef_b : coef_b;
        prec_eff   = (precision == '0) ? qrs_pkg::PREC_W'(1) : precision;
        a_small    = PW'(abs_a) < PW'(prec_eff);
        b_small    = PW'(abs_b) < PW'(prec_eff);
        mode1_next = a_small ? (b_small ? qrs_pkg::ST_DEGEN : qrs_pkg::ST_LINEAR)
                             : qrs_pkg::ST_TWO;
        b2_next    = (2*W)'(abs_b) * (2*W)'(abs_b);
        ax         = (2*W)'(coef_a);
        cx         = (2*W)'(coef_c);
        ac_next    = ax * cx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode1_next;
        b2_reg    <= b2_next;
        ac_reg    <= ac_next;
        a1_reg    <= coef_a;
        b1_reg    <= coef_b;
        c1_reg    <= coef_c;
    end

    // stage 2: discriminant b*b - 4*a*c, exact
    logic signed [DXW-1:0] b2x;
    logic signed [DXW-1:0] acx;
    logic signed [DXW-1:0] d_next;

    logic                  vld2_reg;
    qrs_pkg::status_t      mode2_reg;
    logic signed [DXW-1:0] d_reg;
    logic signed [W-1:0]   a2_reg;
    logic signed [W-1:0]   b2c_reg;
    logic signed [W-1:0]   c2_reg;

    always_comb
    begin
        b2x    = $signed({{(DXW-2*W){1'b0}}, b2_reg});
        acx    = DXW'(ac_reg);
        d_next = b2x - (acx <<< 2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode2_reg <= mode1_reg;
        d_reg     <= d_next;
        a2_reg    <= a1_reg;
        b2c_reg   <= b1_reg;
        c2_reg    <= c1_reg;
    end

    // stage 3: sign check, normalize shift, radicand
    logic [XW-1:0]    dl;
    logic             huge;
    logic [KW-1:0]    k_sel;
    logic [XW-1:0]    x_next;
    qrs_pkg::ctl_t    ctl_next;

    qrs_pkg::ctl_t       ctl_reg;
    logic [XW-1:0]       x_reg;
    logic signed [W-1:0] a3_reg;
    logic signed [W-1:0] b3_reg;
    logic signed [W-1:0] c3_reg;

    always_comb
    begin
        dl    = d_reg[XW-1:0];
        huge  = !d_reg[DXW-1] && (|d_reg[DXW-2:XW]);
        k_sel = '0;
        // the zero test is monotone in k, so the last hit is the largest k
        for (int i = 1; i <= KMAX; i++)
        begin
            if ((dl >> (XW - 2*i)) == '0)
            begin
                k_sel = KW'(i);
            end
        end
        x_next = huge ? d_reg[XW+1:2] : (dl << {k_sel, 1'b0});
        ctl_next.vld   = vld2_reg;
        ctl_next.mode  = (mode2_reg == qrs_pkg::ST_TWO && d_reg[DXW-1])
                         ? qrs_pkg::ST_NO_REAL : mode2_reg;
        ctl_next.k     = huge ? '0 : k_sel;
        ctl_next.huge  = huge;
        ctl_next.neg_p = 1'b0;
        ctl_next.neg_m = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= x_next;
        a3_reg <= a2_reg;
        b3_reg <= b2c_reg;
        c3_reg <= c2_reg;
    end

    assign ctl = ctl_reg;
    assign x   = x_reg;
    assign a   = a3_reg;
    assign b   = b3_reg;
    assign c   = c3_reg;

endmodule

### sv/qrs_sqrt.sv
// ============================================================================
// qrs_sqrt
// pipelined integer square root, two radicand bits per stage
// ============================================================================
module qrs_sqrt #(
    parameter int SIDE_W = 3 * qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  qrs_pkg::ctl_t                    ctl_in,
    input  logic [qrs_pkg::SQRT_IN_W-1:0]    x_in,
    input  logic [SIDE_W-1:0]                side_in,
    output qrs_pkg::ctl_t                    ctl_out,
    output logic [qrs_pkg::SQRT_OUT_W-1:0]   root,
    output logic [SIDE_W-1:0]                side_out
);

    localparam int XW    = qrs_pkg::SQRT_IN_W;
    localparam int RW    = qrs_pkg::SQRT_OUT_W;
    localparam int STEPS = RW;

    qrs_pkg::ctl_t     ctl_reg  [1:STEPS];
    logic [RW-1:0]     root_reg [1:STEPS];
    logic [SIDE_W-1:0] side_reg [1:STEPS];
    logic [XW-1:0]     x_reg    [1:STEPS-1];
    logic [RW:0]       rem_reg  [1:STEPS-1];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        qrs_pkg::ctl_t     ctl_cur;
        logic [RW-1:0]     root_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [XW-1:0]     x_cur;
        logic [RW:0]       rem_cur;
        logic [RW+1:0]     cand;
        logic [RW+1:0]     trial;
        logic [RW+1:0]     diff;
        logic              fit;

        if (i == 0)
        begin : g_first
            assign ctl_cur  = ctl_in;
            assign root_cur = '0;
            assign side_cur = side_in;
            assign x_cur    = x_in;
            assign rem_cur  = '0;
        end
        else
        begin : g_later
            assign ctl_cur  = ctl_reg[i];
            assign root_cur = root_reg[i];
            assign side_cur = side_reg[i];
            assign x_cur    = x_reg[i];
            assign rem_cur  = rem_reg[i];
        end

        // bring down two bits, try root*4+1
        assign cand  = {rem_cur[RW-1:0], x_cur[XW-1:XW-2]};
        assign trial = {root_cur, 2'b01};
        assign fit   = cand >= trial;
        assign diff  = cand - trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i+1] <= '0;
            end
            else
            begin
                ctl_reg[i+1] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            root_reg[i+1] <= {root_cur[RW-2:0], fit};
            side_reg[i+1] <= side_cur;
        end

        if (i < STEPS-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                x_reg[i+1]   <= {x_cur[XW-3:0], 2'b00};
                rem_reg[i+1] <= fit ? diff[RW:0] : cand[RW:0];
            end
        end
    end

    assign ctl_out  = ctl_reg[STEPS];
    assign root     = root_reg[STEPS];
    assign side_out = side_reg[STEPS];

endmodule

### sv/qrs_div.sv
// ============================================================================
// qrs_div
// two-lane pipelined restoring divider, one quotient bit per stage
// ============================================================================
module qrs_div #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qrs_pkg::ctl_t              ctl_in,
    input  logic [COEF_WIDTH+17:0]     num_p,
    input  logic [COEF_WIDTH+17:0]     num_m,
    input  logic [COEF_WIDTH:0]        den,
    output qrs_pkg::ctl_t              ctl_out,
    output logic [COEF_WIDTH+17:0]     quo_p,
    output logic [COEF_WIDTH+17:0]     quo_m
);

    localparam int NW  = COEF_WIDTH + 18;
    localparam int DVW = COEF_WIDTH + 1;

    qrs_pkg::ctl_t  ctl_reg  [1:NW];
    logic [NW-1:0]  nqp_reg  [1:NW];
    logic [NW-1:0]  nqm_reg  [1:NW];
    logic [DVW-1:0] dv_reg   [1:NW-1];
    logic [DVW-1:0] remp_reg [1:NW-1];
    logic [DVW-1:0] remm_reg [1:NW-1];

    for (genvar i = 0; i < NW; i++)
    begin : g_step
        qrs_pkg::ctl_t  ctl_cur;
        logic [NW-1:0]  nqp_cur;
        logic [NW-1:0]  nqm_cur;
        logic [DVW-1:0] dv_cur;
        logic [DVW-1:0] remp_cur;
        logic [DVW-1:0] remm_cur;
        logic [DVW:0]   candp;
        logic [DVW:0]   candm;
        logic [DVW:0]   diffp;
        logic [DVW:0]   diffm;
        logic           fitp;
        logic           fitm;

        if (i == 0)
        begin : g_first
            assign ctl_cur  = ctl_in;
            assign nqp_cur  = num_p;
            assign nqm_cur  = num_m;
            assign dv_cur   = den;
            assign remp_cur = '0;
            assign remm_cur = '0;
        end
        else
        begin : g_later
            assign ctl_cur  = ctl_reg[i];
            assign nqp_cur  = nqp_reg[i];
            assign nqm_cur  = nqm_reg[i];
            assign dv_cur   = dv_reg[i];
            assign remp_cur = remp_reg[i];
            assign remm_cur = remm_reg[i];
        end

        // numerator bits leave at the top, quotient bits enter at the bottom
        assign candp = {remp_cur, nqp_cur[NW-1]};
        assign candm = {remm_cur, nqm_cur[NW-1]};
        assign fitp  = candp >= {1'b0, dv_cur};
        assign fitm  = candm >= {1'b0, dv_cur};
        assign diffp = candp - {1'b0, dv_cur};
        assign diffm = candm - {1'b0, dv_cur};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i+1] <= '0;
            end
            else
            begin
                ctl_reg[i+1] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            nqp_reg[i+1] <= {nqp_cur[NW-2:0], fitp};
            nqm_reg[i+1] <= {nqm_cur[NW-2:0], fitm};
        end

        if (i < NW-1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                dv_reg[i+1]   <= dv_cur;
                remp_reg[i+1] <= fitp ? diffp[DVW-1:0] : candp[DVW-1:0];
                remm_reg[i+1] <= fitm ? diffm[DVW-1:0] : candm[DVW-1:0];
            end
        end
    end

    assign ctl_out = ctl_reg[NW];
    assign quo_p   = nqp_reg[NW];
    assign quo_m   = nqm_reg[NW];

endmodule

### sv/quadratic_root_solver.sv
// ============================================================================
// quadratic_root_solver
// real roots of a*x^2 + b*x + c = 0, q8.8 coefficients in, q16.16 roots out
// ============================================================================
// usage
//   input beat: coef_a, coef_b, coef_c taken at a rising edge with start high
//   and busy low; busy stays low, so a new beat can enter on every cycle
//   result beat: status, root_plus, root_minus and overflow are shown for one
//   cycle with result_valid high; the receiver takes it at the end of that
//   cycle and cannot hold it off, so nothing ever backs up
//   results leave in the order the coefficient sets entered
//   pipeline: 3 front stages, 32 square root stages, 2 numerator stages,
//   COEF_WIDTH + 18 divider stages and 1 output stage
//   throughput: one item per cycle, set by the fully pipelined root and
//   divider chains, one digit per stage
//   config: apb write to byte address 0 sets precision (15 bits, 0 acts as 1);
//   write it only while no beat is in flight
//   reset: all valid bits clear, precision returns to 1, no result is shown
// ============================================================================
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command channel
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COEF_WIDTH-1:0]        coef_a,
    input  logic signed [COEF_WIDTH-1:0]        coef_b,
    input  logic signed [COEF_WIDTH-1:0]        coef_c,
    // result channel
    output logic                                result_valid,
    output logic [1:0]                          status,
    output logic signed [qrs_pkg::ROOT_W-1:0]   root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]   root_minus,
    output logic                                overflow,
    // apb register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qrs_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [qrs_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [qrs_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int W    = COEF_WIDTH;
    localparam int NW   = W + 18;                  // numerator magnitude bits
    localparam int SXW  = (NW + 1 > 49) ? NW + 1 : 49;
    localparam int QXW  = (NW > 33) ? NW : 33;
    localparam int KW   = qrs_pkg::KW;
    localparam int FW   = qrs_pkg::FRAC_W;
    localparam int RTW  = qrs_pkg::ROOT_W;
    localparam int SRW  = qrs_pkg::SQRT_OUT_W;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    logic                       cfg_wr;
    logic [qrs_pkg::PREC_W-1:0] prec_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg <= qrs_pkg::PREC_RESET;
        end
        else if (cfg_wr && paddr[qrs_pkg::APB_ADDR_W-1:2] == qrs_pkg::REG_PRECISION)
        begin
            prec_reg <= pwdata[qrs_pkg::PREC_W-1:0];
        end
    end

    assign prdata = (paddr[qrs_pkg::APB_ADDR_W-1:2] == qrs_pkg::REG_PRECISION)
                    ? qrs_pkg::APB_DATA_W'(prec_reg) : '0;

    // the pipeline never stalls, every start is taken
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // front: class, products, discriminant, radicand
    // ------------------------------------------------------------------
    qrs_pkg::ctl_t               ctl_f;
    logic [qrs_pkg::SQRT_IN_W-1:0] x_f;
    logic signed [W-1:0]         a_f;
    logic signed [W-1:0]         b_f;
    logic signed [W-1:0]         c_f;

    qrs_front #(
        .COEF_WIDTH (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (start & ~busy),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .precision (prec_reg),
        .ctl       (ctl_f),
        .x         (x_f),
        .a         (a_f),
        .b         (b_f),
        .c         (c_f)
    );

    // ------------------------------------------------------------------
    // square root of the scaled discriminant, coefficients ride along
    // ------------------------------------------------------------------
    qrs_pkg::ctl_t      ctl_s;
    logic [SRW-1:0]     root_s;
    logic [3*W-1:0]     side_s;

    qrs_sqrt #(
        .SIDE_W (3*W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_f),
        .x_in     (x_f),
        .side_in  ({a_f, b_f, c_f}),
        .ctl_out  (ctl_s),
        .root     (root_s),
        .side_out (side_s)
    );

    // ------------------------------------------------------------------
    // numerator stage 1: rescale the root, base term and divisor
    // ------------------------------------------------------------------
    logic signed [W-1:0] sa;
    logic signed [W-1:0] sb;
    logic signed [W-1:0] sc;
    logic [SRW:0]        s_val;
    logic [KW-1:0]       amt;
    logic [SXW-1:0]      s_wide;
    logic signed [NW:0]  bx;
    logic signed [NW:0]  cx;
    logic signed [NW:0]  base_next;
    logic signed [W:0]   ax1;
    logic signed [W:0]   bx1;
    logic signed [W:0]   den_next;

    qrs_pkg::ctl_t       ctl1_reg;
    logic signed [NW:0]  sh1_reg;
    logic signed [NW:0]  base1_reg;
    logic signed [W:0]   den1_reg;

    always_comb
    begin
        sa     = side_s[3*W-1:2*W];
        sb     = side_s[2*W-1:W];
        sc     = side_s[W-1:0];
        // huge radicand was taken as d/4, so the root doubles
        s_val  = ctl_s.huge ? {root_s, 1'b0} : {1'b0, root_s};
        amt    = KW'(FW) - ctl_s.k;
        s_wide = SXW'(s_val) << amt;
        bx     = (NW+1)'(sb);
        cx     = (NW+1)'(sc);
        ax1    = (W+1)'(sa);
        bx1    = (W+1)'(sb);
        base_next = ((ctl_s.mode == qrs_pkg::ST_LINEAR) ? -cx : -bx) <<< FW;
        den_next  = (ctl_s.mode == qrs_pkg::ST_LINEAR) ? bx1 : (ax1 <<< 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_s;
        end
    end

    always_ff @(posedge clk)
    begin
        sh1_reg   <= $signed(s_wide[NW:0]);
        base1_reg <= base_next;
        den1_reg  <= den_next;
    end

    // ------------------------------------------------------------------
    // numerator stage 2: both branches, split into sign and magnitude
    // ------------------------------------------------------------------
    logic signed [NW:0] np;
    logic signed [NW:0] nm;
    logic signed [NW:0] np_neg;
    logic signed [NW:0] nm_neg;
    logic signed [W:0]  den_neg;
    qrs_pkg::ctl_t      ctl2_next;

    qrs_pkg::ctl_t      ctl2_reg;
    logic [NW-1:0]      nump2_reg;
    logic [NW-1:0]      numm2_reg;
    logic [W:0]         dv2_reg;

    always_comb
    begin
        np      = base1_reg + ((ctl1_reg.mode == qrs_pkg::ST_LINEAR) ? '0 : sh1_reg);
        nm      = base1_reg - sh1_reg;
        np_neg  = -np;
        nm_neg  = -nm;
        den_neg = -den1_reg;
        ctl2_next       = ctl1_reg;
        ctl2_next.neg_p = np[NW] ^ den1_reg[W];
        ctl2_next.neg_m = nm[NW] ^ den1_reg[W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nump2_reg <= np[NW] ? np_neg[NW-1:0] : np[NW-1:0];
        numm2_reg <= nm[NW] ? nm_neg[NW-1:0] : nm[NW-1:0];
        dv2_reg   <= den1_reg[W] ? den_neg : den1_reg;
    end

    // ------------------------------------------------------------------
    // divider, truncating magnitudes
    // ------------------------------------------------------------------
    qrs_pkg::ctl_t  ctl_d;
    logic [NW-1:0]  quo_p;
    logic [NW-1:0]  quo_m;

    qrs_div #(
        .COEF_WIDTH (W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl2_reg),
        .num_p   (nump2_reg),
        .num_m   (numm2_reg),
        .den     (dv2_reg),
        .ctl_out (ctl_d),
        .quo_p   (quo_p),
        .quo_m   (quo_m)
    );

    // ------------------------------------------------------------------
    // output stage: sign, saturation to q16.16, unused roots to zero
    // ------------------------------------------------------------------
    function automatic logic [RTW:0] sat_root(input logic [NW-1:0] q, input logic neg);
        logic [QXW-1:0] qx;
        logic [RTW-1:0] r;
        logic           o;
        qx = QXW'(q);
        o  = 1'b0;
        r  = neg ? -qx[RTW-1:0] : qx[RTW-1:0];
        if (!neg && qx > QXW'(33'h0_7FFF_FFFF))
        begin
            o = 1'b1;
            r = 32'h7FFF_FFFF;
        end
        else if (neg && qx > QXW'(33'h0_8000_0000))
        begin
            o = 1'b1;
            r = 32'h8000_0000;
        end
        return {o, r};
    endfunction

    logic [RTW:0]      sat_p;
    logic [RTW:0]      sat_m;
    logic [RTW-1:0]    rp_next;
    logic [RTW-1:0]    rm_next;
    logic              ovf_next;

    logic              result_valid_reg;
    qrs_pkg::status_t  status_reg;
    logic [RTW-1:0]    rp_reg;
    logic [RTW-1:0]    rm_reg;
    logic              ovf_reg;

    always_comb
    begin
        sat_p = sat_root(quo_p, ctl_d.neg_p);
        sat_m = sat_root(quo_m, ctl_d.neg_m);
        unique case (ctl_d.mode)
            qrs_pkg::ST_LINEAR:
            begin
                rp_next  = sat_p[RTW-1:0];
                rm_next  = '0;
                ovf_next = sat_p[RTW];
            end
            qrs_pkg::ST_TWO:
            begin
                rp_next  = sat_p[RTW-1:0];
                rm_next  = sat_m[RTW-1:0];
                ovf_next = sat_p[RTW] | sat_m[RTW];
            end
            default:
            begin
                // degenerate or no real roots
                rp_next  = '0;
                rm_next  = '0;
                ovf_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= ctl_d.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= ctl_d.mode;
        rp_reg     <= rp_next;
        rm_reg     <= rm_next;
        ovf_reg    <= ovf_next;
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign root_plus    = rp_reg;
    assign root_minus   = rm_reg;
    assign overflow     = ovf_reg;

endmodule
